### rtl/hrfw_pkg.sv
// Shared types, constants and helpers for the hex record flash writer.
package hrfw_pkg;

	// Reset value of the kept flash address
	localparam logic [31:0] RESET_ADDRESS = 32'h0800_0000;

	// Default depth of the command queue between front and back
	localparam int CMD_FIFO_DEPTH = 4;

	// Record character positions (':' sits at position 0)
	localparam logic [9:0] POS_COUNT_LO  = 10'd1;
	localparam logic [9:0] POS_COUNT_HI  = 10'd2;
	localparam logic [9:0] POS_ADDR_LO   = 10'd3;
	localparam logic [9:0] POS_ADDR_HI   = 10'd6;
	localparam logic [9:0] POS_TYPE      = 10'd8;
	localparam logic [9:0] POS_DATA      = 10'd9;
	localparam logic [9:0] POS_MAX       = 10'd1023;

	// Characters the parser looks at
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_FOUR  = 8'h34;
	localparam logic [7:0] HEX_ALPHA_BIAS = 8'd55;

	// Record kinds
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_UPPER   = 2'd1;
	localparam logic [1:0] KIND_IGNORED = 2'd2;

	// Command opcodes passed from front to back
	localparam logic [1:0] CMD_SET_LOW  = 2'd0;
	localparam logic [1:0] CMD_SET_HIGH = 2'd1;
	localparam logic [1:0] CMD_WRITE    = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] value;
		logic        last;
	} cmd_t;

	// Decode one hex digit; non-digits map to (code - 55) mod 16
	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [7:0] diff;
		begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				diff = c - CHAR_ZERO;
			end else begin
				diff = c - HEX_ALPHA_BIAS;
			end
			digit_value = diff[3:0];
		end
	endfunction

endpackage

### rtl/hrfw_front.sv
// Record parser: tracks position in the record and issues address and write commands.
module hrfw_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ch_valid,
	input  logic [7:0]        ch,
	input  logic              ch_stall,
	output logic              cmd_push,
	output hrfw_pkg::cmd_t    cmd_data
);
	import hrfw_pkg::*;

	logic        in_record_q;
	logic [9:0]  pos_q;
	logic [7:0]  byte_count_q;
	logic [15:0] addr_field_q;
	logic [1:0]  kind_q;
	logic [11:0] nib_q;

	logic        accept;
	logic        is_colon;
	logic [3:0]  d;
	logic [9:0]  k;
	logic [7:0]  group;
	logic [1:0]  sub;
	logic [7:0]  pairs;
	logic        in_data;
	logic        data_active;
	logic        upper_active;

	assign accept   = ch_valid && !ch_stall;
	assign is_colon = (ch == CHAR_COLON);
	assign d        = digit_value(ch);
	assign k        = pos_q - POS_DATA;
	assign group    = k[9:2];
	assign sub      = k[1:0];
	assign pairs    = byte_count_q >> 1;
	assign in_data  = (pos_q >= POS_DATA) && (pos_q < POS_MAX);
	assign data_active  = in_data && (kind_q == KIND_DATA) && (group < pairs);
	assign upper_active = in_data && (kind_q == KIND_UPPER) && (group == 8'd0);

	// Build the command for the current character
	always_comb begin
		cmd_push       = 1'b0;
		cmd_data.op    = CMD_WRITE;
		cmd_data.value = {nib_q[3:0], d, nib_q[11:4]};
		cmd_data.last  = ((group + 8'd1) == pairs);
		if (accept && !is_colon && in_record_q) begin
			if (pos_q == POS_TYPE) begin
				if (ch == CHAR_ZERO) begin
					cmd_push       = 1'b1;
					cmd_data.op    = CMD_SET_LOW;
					cmd_data.value = addr_field_q;
				end
			end else if (data_active && sub == 2'd3) begin
				cmd_push = 1'b1;
			end else if (upper_active && sub == 2'd3) begin
				cmd_push       = 1'b1;
				cmd_data.op    = CMD_SET_HIGH;
				cmd_data.value = {nib_q, d};
			end
		end
	end

	// Advance the record fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_record_q  <= 1'b0;
			pos_q        <= '0;
			byte_count_q <= '0;
			addr_field_q <= '0;
			kind_q       <= KIND_DATA;
			nib_q        <= '0;
		end else if (accept) begin
			if (is_colon) begin
				in_record_q  <= 1'b1;
				pos_q        <= POS_COUNT_LO;
				byte_count_q <= '0;
				addr_field_q <= '0;
				kind_q       <= KIND_IGNORED;
				nib_q        <= '0;
			end else if (in_record_q) begin
				if (pos_q < POS_MAX) begin
					pos_q <= pos_q + 10'd1;
				end
				if (pos_q == POS_COUNT_LO || pos_q == POS_COUNT_HI) begin
					byte_count_q <= {byte_count_q[3:0], d};
				end else if (pos_q >= POS_ADDR_LO && pos_q <= POS_ADDR_HI) begin
					addr_field_q <= {addr_field_q[11:0], d};
				end else if (pos_q == POS_TYPE) begin
					if (ch == CHAR_ZERO) begin
						kind_q <= KIND_DATA;
					end else if (ch == CHAR_FOUR) begin
						kind_q <= KIND_UPPER;
					end else begin
						kind_q <= KIND_IGNORED;
					end
				end else if (data_active || upper_active) begin
					if (sub == 2'd3) begin
						nib_q <= '0;
					end else begin
						nib_q <= {nib_q[7:0], d};
					end
				end
			end
		end
	end

endmodule

### rtl/hrfw_cmd_fifo.sv
// Short command queue between the parser and the write stage.
module hrfw_cmd_fifo #(
	parameter int DEPTH = hrfw_pkg::CMD_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hrfw_pkg::cmd_t    push_data,
	input  logic              pop,
	output hrfw_pkg::cmd_t    pop_data,
	output logic              full,
	output logic              empty
);
	import hrfw_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Store incoming commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/hrfw_back.sv
// Write stage: keeps the flash address and forms halfword write transactions.
module hrfw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  hrfw_pkg::cmd_t    cmd_data,
	output logic              cmd_pop,
	output logic              wr_valid,
	input  logic              wr_stall,
	output logic [31:0]       write_address,
	output logic [15:0]       write_data,
	output logic              last_of_record
);
	import hrfw_pkg::*;

	logic [31:0] full_addr_q;
	logic [6:0]  hw_index_q;
	logic        out_valid_q;
	logic        slot_free;
	logic        is_write;

	assign slot_free = !out_valid_q || !wr_stall;
	assign is_write  = (cmd_data.op == CMD_WRITE);
	assign cmd_pop   = !cmd_empty && (!is_write || slot_free);
	assign wr_valid  = out_valid_q;

	// Apply address commands and track halfword index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_addr_q <= RESET_ADDRESS;
			hw_index_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Hold the write transaction until taken, load a new one on a write
			if (cmd_pop && is_write) begin
				out_valid_q <= 1'b1;
			end else if (!wr_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd_pop) begin
				case (cmd_data.op)
					CMD_SET_LOW: begin
						full_addr_q[15:0] <= cmd_data.value;
						hw_index_q        <= '0;
					end
					CMD_SET_HIGH: begin
						full_addr_q[31:16] <= cmd_data.value;
					end
					CMD_WRITE: begin
						hw_index_q <= hw_index_q + 7'd1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Load the output register for a write
	always_ff @(posedge clk) begin
		if (cmd_pop && is_write) begin
			write_address  <= full_addr_q + {24'd0, hw_index_q, 1'b0};
			write_data     <= cmd_data.value;
			last_of_record <= cmd_data.last;
		end
	end

endmodule

### rtl/hex_record_flash_writer_top.sv
// Top level of the hex record flash writer.
// Takes one ASCII character of an Intel HEX stream per transaction on the ch
// channel and issues halfword flash writes on the wr channel. The parser accepts
// a character every cycle while ch_stall is low; a short command queue decouples
// it from the write stage, so ch_stall rises only when that queue is full. A data
// record yields one write per four data digits; each goes through the queue and
// the write stage's output register. The kept address resets to 0x08000000.
module hex_record_flash_writer_top #(
	parameter int FIFO_DEPTH = hrfw_pkg::CMD_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ch_valid,
	output logic        ch_stall,
	input  logic [7:0]  ch,
	output logic        wr_valid,
	input  logic        wr_stall,
	output logic [31:0] write_address,
	output logic [15:0] write_data,
	output logic        last_of_record
);
	import hrfw_pkg::*;

	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_pop;
	logic cmd_full;
	logic cmd_empty;

	assign ch_stall = cmd_full;

	hrfw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch_valid (ch_valid),
		.ch       (ch),
		.ch_stall (ch_stall),
		.cmd_push (cmd_push),
		.cmd_data (cmd_in)
	);

	hrfw_cmd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.pop       (cmd_pop),
		.pop_data  (cmd_out),
		.full      (cmd_full),
		.empty     (cmd_empty)
	);

	hrfw_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_empty      (cmd_empty),
		.cmd_data       (cmd_out),
		.cmd_pop        (cmd_pop),
		.wr_valid       (wr_valid),
		.wr_stall       (wr_stall),
		.write_address  (write_address),
		.write_data     (write_data),
		.last_of_record (last_of_record)
	);

endmodule
